// ===== hw/rtl/tli_pkg.sv =====
// Shared types and constants for the table linear interpolator.
// Used by tli_front, tli_back and table_linear_interpolator.
`timescale 1ns / 1ps

package tli_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   // Field widths of the ports.
   localparam int ENTRY_INDEX_W = 10;
   localparam int POINTS_W      = 11;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Number of quotient bits produced by the divider.
   localparam int DIV_STEPS = VALUE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Operation codes on the input channel.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Item classes decided by the front.
   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_QUERY,
      KIND_SHORT
   } tli_kind_type;

   // One queued item.
   typedef struct packed {
      tli_kind_type       kind;
      logic [IDX_W-1:0]   index;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } tli_item_type;

endpackage

// ===== hw/rtl/tli_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Has no dependencies.
`timescale 1ns / 1ps

module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on request; the read data is registered every cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/tli_front.sv =====
// Front end: accepts input items, holds the point count register, classifies
// items and queues them for the back end. Depends on tli_pkg.
`timescale 1ns / 1ps

module tli_front
   import tli_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_operation,
   input  logic [ENTRY_INDEX_W-1:0]        req_entry_index,
   input  logic [KEY_W-1:0]                req_key,
   input  logic signed [VALUE_W-1:0]       req_entry_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [POINTS_W-1:0]             csr_points_in_use,
   output logic [CNT_W-1:0]                points,
   output logic                            q_valid,
   output tli_item_type                    q_item,
   input  logic                            q_pop
);

   logic [CNT_W-1:0]  points_ff, points_in;
   tli_item_type      queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              accept;
   logic              keep;
   tli_item_type      item;

   // The count register takes a write in any cycle; counts beyond the table saturate.
   assign csr_ready = 1'b1;
   always_comb begin
      points_in = points_ff;
      if (csr_valid) begin
         if (32'(csr_points_in_use) > 32'(TABLE_DEPTH)) begin
            points_in = CNT_W'(TABLE_DEPTH);
         end else begin
            points_in = CNT_W'(csr_points_in_use);
         end
      end
   end
   assign points = points_ff;

   // Classify the incoming item; a load outside the table is dropped.
   always_comb begin
      item.index = IDX_W'(req_entry_index);
      item.key   = req_key;
      item.value = req_entry_value;
      keep       = 1'b1;
      if (req_operation == OP_QUERY) begin
         item.kind = (points_ff < CNT_W'(2)) ? KIND_SHORT : KIND_QUERY;
      end else begin
         item.kind = KIND_LOAD;
         keep      = 32'(req_entry_index) < 32'(TABLE_DEPTH);
      end
   end

   // Queue bookkeeping.
   assign full    = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign accept  = push && !full;
   assign q_valid = count_ff != '0;
   assign q_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if ((accept && keep) && !q_pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (!(accept && keep) && q_pop) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         points_ff <= points_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (accept && keep) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== hw/rtl/tli_back.sv =====
// Back end: table memories, lower-bound search, interpolation with a
// bit-serial divider, and the result register. Depends on tli_pkg and tli_ram.
`timescale 1ns / 1ps

module tli_back
   import tli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CNT_W-1:0]          points,
   input  logic                      q_valid,
   input  tli_item_type              q_item,
   output logic                      q_pop,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic                      rsp_out_of_range
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SEARCH,
      S_PROBE,
      S_PAIR_LO,
      S_PAIR_HI,
      S_MUL,
      S_DIV,
      S_FINISH,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [KEY_W-1:0]      t_ff, t_in;
   logic [VALUE_W-1:0]    v0_ff, v0_in;
   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic [CNT_W-1:0]      mid_ff, mid_in;
   logic [KEY_W-1:0]      k1_ff, k1_in;
   logic [VALUE_W-1:0]    s1_ff, s1_in;
   logic [KEY_W-1:0]      den_ff, den_in;
   logic [KEY_W-1:0]      num_ff, num_in;
   logic [VALUE_W-1:0]    mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [KEY_W-1:0]      rem_ff, rem_in;
   logic [VALUE_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VALUE_W-1:0]    pend_value_ff, pend_value_in;
   logic                  pend_oor_ff, pend_oor_in;
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]    out_value_ff, out_value_in;
   logic                  out_oor_ff, out_oor_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [KEY_W-1:0]      key_rd;
   logic [VALUE_W-1:0]    val_rd;
   logic [CNT_W-1:0]      span;
   logic [CNT_W-1:0]      mid_calc;
   logic [CNT_W-1:0]      last_idx;
   logic [CNT_W-1:0]      lo_less;
   logic [VALUE_W:0]      delta;
   logic [VALUE_W:0]      delta_abs;
   logic [KEY_W-1:0]      offset;
   logic [KEY_W-1:0]      gap;
   logic [2*KEY_W-1:0]    product;
   logic [KEY_W:0]        trial;
   logic [KEY_W:0]        trial_sub;
   logic                  trial_ge;
   logic [VALUE_W:0]      interp;

   // Breakpoint storage.
   tli_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (q_item.index),
      .wr_data (q_item.key),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   tli_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (q_item.index),
      .wr_data (q_item.value),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   // Search arithmetic.
   assign span     = hi_ff - lo_ff;
   assign mid_calc = lo_ff + (span >> 1);
   assign last_idx = points - CNT_W'(1);
   assign lo_less  = lo_ff - CNT_W'(1);

   // Interpolation arithmetic; key_rd and val_rd hold the upper neighbor here.
   assign delta     = {val_rd[VALUE_W-1], val_rd} - {s1_ff[VALUE_W-1], s1_ff};
   assign delta_abs = delta[VALUE_W] ? (~delta + (VALUE_W + 1)'(1)) : delta;
   assign offset    = t_ff - k1_ff;
   assign gap       = key_rd - k1_ff;
   assign product   = mag_ff * num_ff;

   // One restoring division step; the remainder always stays below the divisor.
   assign trial     = {rem_ff, quo_ff[VALUE_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = trial >= {1'b0, den_ff};

   assign interp = neg_ff ? ({s1_ff[VALUE_W-1], s1_ff} - {1'b0, quo_ff})
                          : ({s1_ff[VALUE_W-1], s1_ff} + {1'b0, quo_ff});

   // Sequencer: next state and next register values.
   always_comb begin
      state_in      = state_ff;
      t_in          = t_ff;
      v0_in         = v0_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      k1_in         = k1_ff;
      s1_in         = s1_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      pend_value_in = pend_value_ff;
      pend_oor_in   = pend_oor_ff;
      out_value_in  = out_value_ff;
      out_oor_in    = out_oor_ff;
      out_valid_in  = (pop && out_valid_ff) ? 1'b0 : out_valid_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         // Take the next queued item; loads complete here.
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_item.kind)
                  KIND_LOAD: begin
                     wr_en = 1'b1;
                  end
                  KIND_SHORT: begin
                     pend_value_in = '0;
                     pend_oor_in   = 1'b1;
                     state_in      = S_EMIT;
                  end
                  KIND_QUERY: begin
                     t_in     = q_item.key;
                     rd_addr  = '0;
                     state_in = S_FIRST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // First entry is read; check the lower bound of the table.
         S_FIRST: begin
            if (t_ff < key_rd) begin
               pend_value_in = '0;
               pend_oor_in   = 1'b1;
               state_in      = S_EMIT;
            end else begin
               v0_in    = val_rd;
               rd_addr  = last_idx[IDX_W-1:0];
               state_in = S_LAST;
            end
         end
         // Last entry is read; check the upper bound of the table.
         S_LAST: begin
            if (t_ff > key_rd) begin
               pend_value_in = '0;
               pend_oor_in   = 1'b1;
               state_in      = S_EMIT;
            end else begin
               lo_in    = '0;
               hi_in    = points;
               state_in = S_SEARCH;
            end
         end
         // Issue the next probe, or resolve the search once the range is empty.
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               rd_addr  = mid_calc[IDX_W-1:0];
               state_in = S_PROBE;
            end else if (lo_ff == '0) begin
               pend_value_in = v0_ff;
               pend_oor_in   = 1'b0;
               state_in      = S_EMIT;
            end else if (lo_ff >= points) begin
               pend_value_in = '0;
               pend_oor_in   = 1'b1;
               state_in      = S_EMIT;
            end else begin
               rd_addr  = lo_less[IDX_W-1:0];
               state_in = S_PAIR_LO;
            end
         end
         // Narrow the search range by the probed key.
         S_PROBE: begin
            if (key_rd < t_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         // Lower neighbor is read; fetch the upper one.
         S_PAIR_LO: begin
            k1_in    = key_rd;
            s1_in    = val_rd;
            rd_addr  = lo_ff[IDX_W-1:0];
            state_in = S_PAIR_HI;
         end
         // Upper neighbor is read; set up the scaled step, or emit the lower value if the pair cannot be used.
         S_PAIR_HI: begin
            if ((key_rd <= k1_ff) || (t_ff < k1_ff)) begin
               pend_value_in = s1_ff;
               pend_oor_in   = 1'b0;
               state_in      = S_EMIT;
            end else begin
               den_in   = gap;
               num_in   = (offset > gap) ? gap : offset;
               mag_in   = delta_abs[VALUE_W-1:0];
               neg_in   = delta[VALUE_W];
               state_in = S_MUL;
            end
         end
         // Product of step magnitude and offset; its high half starts the remainder.
         S_MUL: begin
            rem_in   = product[2*KEY_W-1:KEY_W];
            quo_in   = product[KEY_W-1:0];
            cnt_in   = DIV_CNT_W'(DIV_STEPS - 1);
            state_in = S_DIV;
         end
         // One quotient bit per cycle.
         S_DIV: begin
            rem_in = trial_ge ? trial_sub[KEY_W-1:0] : trial[KEY_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], trial_ge};
            cnt_in = cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         // Apply the truncated step to the lower value.
         S_FINISH: begin
            pend_value_in = interp[VALUE_W-1:0];
            pend_oor_in   = 1'b0;
            state_in      = S_EMIT;
         end
         // Hand the result to the output register once it is free.
         S_EMIT: begin
            if (!out_valid_ff || pop) begin
               out_value_in = pend_value_ff;
               out_oor_in   = pend_oor_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      t_ff          <= t_in;
      v0_ff         <= v0_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      k1_ff         <= k1_in;
      s1_ff         <= s1_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      pend_value_ff <= pend_value_in;
      pend_oor_ff   <= pend_oor_in;
      out_value_ff  <= out_value_in;
      out_oor_ff    <= out_oor_in;
   end

   // Result channel.
   assign empty            = !out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_out_of_range = out_oor_ff;

endmodule

// ===== hw/rtl/table_linear_interpolator.sv =====
// Piecewise linear interpolation table. A load is written to the table when the
// back end takes it from the queue. A query checks both table bounds, runs a binary
// search of P probes (at most 11 with 1024 points) with one table memory read per
// probe, reads the neighbor pair, multiplies, and runs the one-bit-per-cycle divider.
// Items are worked one at a time; a four-entry queue takes new transfers meanwhile.
// Reset clears the control state and the point count; table entries hold no reset value.
`timescale 1ns / 1ps

module table_linear_interpolator
   import tli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_operation,
   input  logic [ENTRY_INDEX_W-1:0]  req_entry_index,
   input  logic [KEY_W-1:0]          req_key,
   input  logic signed [VALUE_W-1:0] req_entry_value,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic                      rsp_out_of_range,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [POINTS_W-1:0]       csr_points_in_use
);

   logic [CNT_W-1:0] points;
   logic             q_valid;
   tli_item_type     q_item;
   logic             q_pop;

   // Intake, point count register and item queue.
   tli_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_key           (req_key),
      .req_entry_value   (req_entry_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_points_in_use (csr_points_in_use),
      .points            (points),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // Table, search, interpolation and result register.
   tli_back u_back (
      .clock            (clock),
      .reset            (reset),
      .points           (points),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_value (rsp_result_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule
